### rtl/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;
	localparam int unsigned DEF_COLUMNS = 80;
	localparam int unsigned DEF_ROWS    = 25;
	localparam int unsigned CMD_W       = 2;
	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned IDX_W       = 11;
	localparam int unsigned ATTR_W      = 8;
	localparam int unsigned TAB_W       = 4;
	localparam int unsigned CELL_W      = CHAR_W + ATTR_W;

	localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
	localparam logic [CHAR_W-1:0] NL_CHAR    = 8'h0A;
	localparam logic [CHAR_W-1:0] TAB_CHAR   = 8'h09;
	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
	localparam logic [TAB_W-1:0]  RESET_TABS = 4'd5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_BS    = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [0:0] {
		REG_FILL_ATTR = 1'b0,
		REG_TAB_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_CHAR,
		OP_NL,
		OP_TAB,
		OP_BS,
		OP_CLEAR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
	} item_t;
endpackage

### rtl/tcw_ram.sv
`timescale 1ns / 1ps
module tcw_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/tcw_front.sv
`timescale 1ns / 1ps
module tcw_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       enable,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tcw_pkg::CMD_W-1:0]  command,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::IDX_W-1:0]  cell_index,
	output logic                       q_valid,
	output tcw_pkg::item_t             q_item,
	input  logic                       q_pop
);
	tcw_pkg::item_t ent_q [2];
	tcw_pkg::item_t cls;
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           push;

	// classify the command into an operation for the back end
	always_comb begin
		cls.ch  = char_code;
		cls.idx = cell_index;
		unique case (tcw_pkg::cmd_t'(command))
			tcw_pkg::CMD_PUT: begin
				if (char_code == tcw_pkg::NL_CHAR) begin
					cls.op = tcw_pkg::OP_NL;
				end else if (char_code == tcw_pkg::TAB_CHAR) begin
					cls.op = tcw_pkg::OP_TAB;
				end else begin
					cls.op = tcw_pkg::OP_CHAR;
				end
			end
			tcw_pkg::CMD_BS:    cls.op = tcw_pkg::OP_BS;
			tcw_pkg::CMD_CLEAR: cls.op = tcw_pkg::OP_CLEAR;
			tcw_pkg::CMD_READ:  cls.op = tcw_pkg::OP_READ;
			default:            cls.op = tcw_pkg::OP_READ;
		endcase
	end

	assign in_ready = enable && (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

### rtl/tcw_back.sv
`timescale 1ns / 1ps
module tcw_back #(
	parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [tcw_pkg::ATTR_W-1:0] fill_attr,
	input  logic [tcw_pkg::TAB_W-1:0]  tab_count,
	input  logic                       q_valid,
	input  tcw_pkg::item_t             q_item,
	output logic                       q_pop,
	output logic                       init_busy,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tcw_pkg::IDX_W-1:0]  cursor_cell,
	output logic [tcw_pkg::CHAR_W-1:0] read_char,
	output logic [tcw_pkg::ATTR_W-1:0] read_attr,
	output logic                       scrolled
);
	localparam int unsigned TOTAL = COLUMNS * ROWS;
	localparam int unsigned AW    = $clog2(TOTAL);
	localparam int unsigned CW    = $clog2(TOTAL + 1);
	localparam int unsigned COLW  = $clog2(COLUMNS);
	localparam logic [CW-1:0]   CUR_END  = CW'(TOTAL);
	localparam logic [CW-1:0]   CUR_COLS = CW'(COLUMNS);
	localparam logic [AW-1:0]   SW_LAST  = AW'(TOTAL - 1);
	localparam logic [AW-1:0]   SW_COPY  = AW'(TOTAL - COLUMNS - 1);
	localparam logic [AW-1:0]   SW_BLANK = AW'(TOTAL - COLUMNS);
	localparam logic [AW-1:0]   SW_COLS  = AW'(COLUMNS);
	localparam logic [COLW-1:0] COL_LAST = COLW'(COLUMNS - 1);

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_TAB, ST_CHECK, ST_SCROLL, ST_SBLANK, ST_CLEAR, ST_READ
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              cur_q;
	logic [COLW-1:0]            col_q;
	tcw_pkg::op_t               op_q;
	logic [tcw_pkg::TAB_W-1:0]  tab_q;
	logic                       scr_q;
	logic                       rd_ok_q;
	logic [AW-1:0]              sweep_q;
	logic                       wr_pend_s1;
	logic [AW-1:0]              wr_addr_s1;

	logic                       we;
	logic [AW-1:0]              waddr, raddr;
	logic [tcw_pkg::CELL_W-1:0] wdata, rdata, blank_cell;
	logic                       take, rd_in_range;

	assign blank_cell  = {fill_attr, tcw_pkg::BLANK_CHAR};
	assign take        = (state_q == ST_IDLE) && q_valid && !out_valid;
	assign q_pop       = take;
	assign init_busy   = (state_q == ST_INIT);
	assign rd_in_range = (32'(q_item.idx) < 32'(TOTAL));

	always_comb begin
		we    = 1'b0;
		waddr = AW'(cur_q);
		wdata = blank_cell;
		raddr = AW'(q_item.idx);
		if (state_q == ST_SCROLL) begin
			raddr = sweep_q + SW_COLS;
		end
		if (wr_pend_s1) begin
			we    = 1'b1;
			waddr = wr_addr_s1;
			wdata = rdata;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					we    = 1'b1;
					waddr = sweep_q;
					wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
				end
				ST_CLEAR, ST_SBLANK: begin
					we    = 1'b1;
					waddr = sweep_q;
				end
				ST_IDLE: begin
					if (take && q_item.op == tcw_pkg::OP_CHAR) begin
						we    = 1'b1;
						wdata = {fill_attr, q_item.ch};
					end else if (take && q_item.op == tcw_pkg::OP_BS && cur_q != '0) begin
						we    = 1'b1;
						waddr = AW'(cur_q - CW'(1));
					end
				end
				ST_TAB: begin
					we = (tab_q != '0) && (cur_q != CUR_END);
				end
				default: we = 1'b0;
			endcase
		end
	end

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(TOTAL)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cur_q       <= '0;
			col_q       <= '0;
			op_q        <= tcw_pkg::OP_CHAR;
			tab_q       <= '0;
			scr_q       <= 1'b0;
			rd_ok_q     <= 1'b0;
			sweep_q     <= '0;
			wr_pend_s1  <= 1'b0;
			wr_addr_s1  <= '0;
			out_valid   <= 1'b0;
			cursor_cell <= '0;
			read_char   <= '0;
			read_attr   <= '0;
			scrolled    <= 1'b0;
		end else begin
			wr_pend_s1 <= (state_q == ST_SCROLL);
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (sweep_q == SW_LAST) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_IDLE: begin
					if (take) begin
						op_q    <= q_item.op;
						scr_q   <= 1'b0;
						sweep_q <= '0;
						unique case (q_item.op)
							tcw_pkg::OP_CHAR: begin
								cur_q   <= cur_q + CW'(1);
								col_q   <= (col_q == COL_LAST) ? '0 : col_q + COLW'(1);
								state_q <= ST_CHECK;
							end
							tcw_pkg::OP_NL: begin
								cur_q   <= cur_q + CUR_COLS - CW'(col_q);
								col_q   <= '0;
								state_q <= ST_CHECK;
							end
							tcw_pkg::OP_TAB: begin
								tab_q   <= tab_count;
								state_q <= ST_TAB;
							end
							tcw_pkg::OP_BS: begin
								if (cur_q != '0) begin
									cur_q <= cur_q - CW'(1);
									col_q <= (col_q == '0) ? COL_LAST : col_q - COLW'(1);
								end
								state_q <= ST_CHECK;
							end
							tcw_pkg::OP_CLEAR: state_q <= ST_CLEAR;
							tcw_pkg::OP_READ: begin
								rd_ok_q <= rd_in_range;
								state_q <= ST_READ;
							end
							default: state_q <= ST_CHECK;
						endcase
					end
				end
				ST_TAB: begin
					if (tab_q == '0) begin
						state_q <= ST_CHECK;
					end else if (cur_q == CUR_END) begin
						scr_q   <= 1'b1;
						sweep_q <= '0;
						state_q <= ST_SCROLL;
					end else begin
						cur_q <= cur_q + CW'(1);
						col_q <= (col_q == COL_LAST) ? '0 : col_q + COLW'(1);
						tab_q <= tab_q - tcw_pkg::TAB_W'(1);
					end
				end
				ST_CHECK: begin
					if (cur_q == CUR_END) begin
						scr_q   <= 1'b1;
						sweep_q <= '0;
						state_q <= ST_SCROLL;
					end else begin
						out_valid   <= 1'b1;
						cursor_cell <= tcw_pkg::IDX_W'(cur_q);
						read_char   <= '0;
						read_attr   <= '0;
						scrolled    <= scr_q;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCROLL: begin
					// copy each row up one: read below, write the cell in the cycle after
					wr_addr_s1 <= sweep_q;
					if (sweep_q == SW_COPY) begin
						sweep_q <= SW_BLANK;
						state_q <= ST_SBLANK;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_SBLANK: begin
					// hold while the last copy write drains
					if (!wr_pend_s1) begin
						if (sweep_q == SW_LAST) begin
							cur_q   <= cur_q - CUR_COLS;
							state_q <= (op_q == tcw_pkg::OP_TAB) ? ST_TAB : ST_CHECK;
						end else begin
							sweep_q <= sweep_q + AW'(1);
						end
					end
				end
				ST_CLEAR: begin
					if (sweep_q == SW_LAST) begin
						cur_q   <= '0;
						col_q   <= '0;
						state_q <= ST_CHECK;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				ST_READ: begin
					out_valid   <= 1'b1;
					cursor_cell <= tcw_pkg::IDX_W'(cur_q);
					read_char   <= rd_ok_q ? rdata[tcw_pkg::CHAR_W-1:0] : '0;
					read_attr   <= rd_ok_q ? rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
					scrolled    <= 1'b0;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### rtl/text_console_writer_core.sv
`timescale 1ns / 1ps
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    command, char_code, cell_index
// out      source     out_valid / out_ready  cursor_cell, read_char, read_attr, scrolled
// cfg      sink       cfg_we                 cfg_index, cfg_data
//
// Each scroll copies the rows up and blanks the bottom row through the one write port of
// the cell RAM. The next item is taken only once the result has left, so the back end
// works on one item at a time.
// After reset a clearing pass blanks the RAM; in_ready is low then.
// A two-entry queue takes items while a result waits on out_ready.
module text_console_writer_core #(
	parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [tcw_pkg::CMD_W-1:0]  command,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::IDX_W-1:0]  cell_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tcw_pkg::IDX_W-1:0]  cursor_cell,
	output logic [tcw_pkg::CHAR_W-1:0] read_char,
	output logic [tcw_pkg::ATTR_W-1:0] read_attr,
	output logic                       scrolled,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [tcw_pkg::ATTR_W-1:0] cfg_data
);
	logic [tcw_pkg::ATTR_W-1:0] fill_q;
	logic [tcw_pkg::TAB_W-1:0]  tabs_q;
	logic                       q_valid, q_pop, init_busy;
	tcw_pkg::item_t             q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= tcw_pkg::RESET_ATTR;
			tabs_q <= tcw_pkg::RESET_TABS;
		end else if (cfg_we) begin
			unique case (tcw_pkg::reg_idx_t'(cfg_index))
				tcw_pkg::REG_FILL_ATTR: fill_q <= cfg_data;
				tcw_pkg::REG_TAB_COUNT: tabs_q <= cfg_data[tcw_pkg::TAB_W-1:0];
				default: fill_q <= fill_q;
			endcase
		end
	end

	tcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.enable    (!init_busy),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.char_code (char_code),
		.cell_index(cell_index),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fill_attr  (fill_q),
		.tab_count  (tabs_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.init_busy  (init_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cursor_cell(cursor_cell),
		.read_char  (read_char),
		.read_attr  (read_attr),
		.scrolled   (scrolled)
	);
endmodule

### rtl/tcw_checker.sv
`timescale 1ns / 1ps
module tcw_checker #(
	parameter int unsigned COLUMNS = tcw_pkg::DEF_COLUMNS,
	parameter int unsigned ROWS    = tcw_pkg::DEF_ROWS
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [tcw_pkg::IDX_W-1:0]  cursor_cell,
	input logic                       scrolled
);
	localparam int unsigned TOTAL = COLUMNS * ROWS;
	localparam bit FITS = (TOTAL <= 2048);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(cursor_cell)) else $error("result changed while stalled");

	a_init_block: assert property (@(posedge clk)
		$rose(arst_n) |-> !in_ready) else $error("item taken during clearing pass");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && FITS |-> 32'(cursor_cell) < 32'(TOTAL)) else $error("cursor beyond screen");

	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scrolled && FITS |-> 32'(cursor_cell) >= 32'(TOTAL - COLUMNS))
		else $error("scroll left cursor above bottom row");
endmodule

bind text_console_writer_core tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.cursor_cell(cursor_cell),
	.scrolled   (scrolled)
);

### bench/console_shadow.sv
`timescale 1ns / 1ps
module console_shadow
	import tcw_pkg::*;
#(
	parameter int unsigned COLUMNS = DEF_COLUMNS,
	parameter int unsigned ROWS    = DEF_ROWS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic [CMD_W-1:0]  command,
	input  logic [CHAR_W-1:0] char_code,
	input  logic [IDX_W-1:0]  cell_index,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [IDX_W-1:0]  cursor_cell,
	input  logic [CHAR_W-1:0] read_char,
	input  logic [ATTR_W-1:0] read_attr,
	input  logic              scrolled,
	input  logic              cfg_we,
	input  logic [0:0]        cfg_index,
	input  logic [ATTR_W-1:0] cfg_data,
	output int                mismatches,
	output int                results_due,
	output int                scroll_seen
);
	localparam int unsigned CELLS = COLUMNS * ROWS;

	typedef struct {
		logic [IDX_W-1:0]  cur;
		logic [CHAR_W-1:0] ch;
		logic [ATTR_W-1:0] attr;
		logic              scr;
	} console_result_t;

	logic [CELL_W-1:0] screen [CELLS];
	int unsigned       cursor;
	logic [ATTR_W-1:0] fill_attr;
	logic [TAB_W-1:0]  tab_count;
	logic              did_scroll;
	console_result_t   results_q[$];

	function automatic logic [CELL_W-1:0] blank_cell();
		return {fill_attr, BLANK_CHAR};
	endfunction

	function automatic void scroll_screen();
		for (int i = 0; i < CELLS - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (int i = CELLS - COLUMNS; i < CELLS; i++)
			screen[i] = blank_cell();
		cursor = (cursor >= COLUMNS) ? cursor - COLUMNS : 0;
		did_scroll = 1'b1;
	endfunction

	function automatic void write_cell(logic [CHAR_W-1:0] ch);
		if (cursor >= CELLS)
			scroll_screen();
		if (cursor < CELLS)
			screen[cursor] = {fill_attr, ch};
		cursor++;
	endfunction

	function automatic console_result_t apply_command(cmd_t cmd, logic [CHAR_W-1:0] ch,
			logic [IDX_W-1:0] idx);
		console_result_t r;
		r.ch = '0;
		r.attr = '0;
		did_scroll = 1'b0;
		case (cmd)
			CMD_PUT: begin
				if (ch == NL_CHAR)
					cursor += COLUMNS - (cursor % COLUMNS);
				else if (ch == TAB_CHAR)
					for (int j = 0; j < tab_count; j++)
						write_cell(BLANK_CHAR);
				else
					write_cell(ch);
				if (cursor >= CELLS)
					scroll_screen();
			end
			CMD_BS: begin
				if (cursor > 0) begin
					cursor--;
					if (cursor < CELLS)
						screen[cursor] = blank_cell();
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen[i] = blank_cell();
				cursor = 0;
			end
			default: begin
				if (idx < CELLS)
					{r.attr, r.ch} = screen[idx];
			end
		endcase
		r.cur = cursor[IDX_W-1:0];
		r.scr = did_scroll;
		return r;
	endfunction

	assign results_due = results_q.size();

	always @(posedge clk or negedge arst_n) begin
		console_result_t e;
		if (!arst_n) begin
			fill_attr <= RESET_ATTR;
			tab_count <= RESET_TABS;
			cursor = 0;
			for (int i = 0; i < CELLS; i++)
				screen[i] = {RESET_ATTR, BLANK_CHAR};
			results_q.delete();
			mismatches <= 0;
			scroll_seen <= 0;
		end else begin
			if (cfg_we) begin
				if (reg_idx_t'(cfg_index) == REG_FILL_ATTR)
					fill_attr <= cfg_data;
				else
					tab_count <= cfg_data[TAB_W-1:0];
			end
			if (in_valid && in_ready) begin
				e = apply_command(cmd_t'(command), char_code, cell_index);
				results_q.push_back(e);
			end
			if (out_valid && out_ready) begin
				if (results_q.size() == 0) begin
					$display("%0t: result with nothing expected: cur %0d char %h attr %h scr %b",
						$time, cursor_cell, read_char, read_attr, scrolled);
					mismatches <= mismatches + 1;
				end else begin
					e = results_q.pop_front();
					if (e.scr)
						scroll_seen <= scroll_seen + 1;
					if (e.cur !== cursor_cell || e.ch !== read_char || e.attr !== read_attr
							|| e.scr !== scrolled) begin
						$display("%0t: mismatch expected cur %0d char %h attr %h scr %b",
							$time, e.cur, e.ch, e.attr, e.scr);
						$display("%0t:          actual   cur %0d char %h attr %h scr %b",
							$time, cursor_cell, read_char, read_attr, scrolled);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import tcw_pkg::*;

	localparam int unsigned CELLS     = DEF_COLUMNS * DEF_ROWS;
	localparam int          STALL_MAX = 30000;
	localparam int          PHASE_LEN = 360;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [CMD_W-1:0]  command = '0;
	logic [CHAR_W-1:0] char_code = '0;
	logic [IDX_W-1:0]  cell_index = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [IDX_W-1:0]  cursor_cell;
	logic [CHAR_W-1:0] read_char;
	logic [ATTR_W-1:0] read_attr;
	logic              scrolled;
	logic              cfg_we = 1'b0;
	logic [0:0]        cfg_index = '0;
	logic [ATTR_W-1:0] cfg_data = '0;

	int  mismatches, results_due, scroll_seen;
	int  results_taken = 0;
	int  idle_cycles = 0;
	int  items_sent = 0;
	bit  steady = 1'b0;

	text_console_writer_core i_dut (.*);

	console_shadow i_shadow (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, one long hold-off after some results
	always @(negedge clk) begin
		int hold;
		if (results_taken == 100 && hold == 0) begin
			hold = 400;
		end
		if (hold > 1) begin
			out_ready = 1'b0;
			hold--;
		end else begin
			if (hold == 1 && results_taken == 100)
				hold = 1;
			else
				hold = 0;
			out_ready = steady || ($urandom_range(0, 99) >= 34);
			if (hold == 1)
				out_ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			results_taken <= results_taken + 1;
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_MAX) begin
			$display("watchdog: no progress for %0d cycles", STALL_MAX);
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_cmd(cmd_t cmd, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
		if (!steady && $urandom_range(0, 99) < 34) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		command = cmd;
		char_code = ch;
		cell_index = idx;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (results_due != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [ATTR_W-1:0] value);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_cmd();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			send_cmd(CMD_PUT, NL_CHAR, IDX_W'($urandom));
		else if (pick < 12)
			send_cmd(CMD_PUT, TAB_CHAR, IDX_W'($urandom));
		else if (pick < 68)
			send_cmd(CMD_PUT, CHAR_W'($urandom), IDX_W'($urandom));
		else if (pick < 79)
			send_cmd(CMD_BS, CHAR_W'($urandom), IDX_W'($urandom));
		else if (pick < 80)
			send_cmd(CMD_CLEAR, CHAR_W'($urandom), IDX_W'($urandom));
		else if (pick < 95)
			send_cmd(CMD_READ, CHAR_W'($urandom), IDX_W'($urandom_range(0, CELLS - 1)));
		else
			send_cmd(CMD_READ, CHAR_W'($urandom), IDX_W'($urandom_range(CELLS, 2047)));
	endtask

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: home backspace, char extremes, control chars, reads at the edges
		send_cmd(CMD_BS, 8'h00, '0);
		send_cmd(CMD_PUT, 8'h00, '0);
		send_cmd(CMD_PUT, 8'hFF, 11'h7FF);
		send_cmd(CMD_PUT, 8'h41, '0);
		send_cmd(CMD_PUT, TAB_CHAR, '0);
		send_cmd(CMD_PUT, NL_CHAR, '0);
		send_cmd(CMD_READ, 8'h00, 11'd0);
		send_cmd(CMD_READ, 8'h00, 11'd1);
		send_cmd(CMD_READ, 8'h00, 11'd7);
		send_cmd(CMD_READ, 8'h00, 11'(CELLS - 1));
		send_cmd(CMD_READ, 8'h00, 11'(CELLS));
		send_cmd(CMD_READ, 8'hFF, 11'h7FF);
		send_cmd(CMD_BS, 8'hFF, '0);
		send_cmd(CMD_READ, 8'h00, 11'd80);
		send_cmd(CMD_CLEAR, 8'h00, '0);
		send_cmd(CMD_READ, 8'h00, 11'd0);
		drain();
		write_reg(REG_TAB_COUNT, 8'h00);
		send_cmd(CMD_PUT, TAB_CHAR, '0);
		send_cmd(CMD_PUT, 8'h55, '0);
		send_cmd(CMD_READ, 8'h00, 11'd0);

		for (int phase = 0; phase < 5; phase++) begin
			drain();
			case (phase)
				0: begin
					write_reg(REG_FILL_ATTR, 8'h07);
					write_reg(REG_TAB_COUNT, 8'h05);
				end
				1: begin
					write_reg(REG_FILL_ATTR, 8'h00);
					write_reg(REG_TAB_COUNT, 8'h0F);
				end
				2: begin
					write_reg(REG_FILL_ATTR, 8'hFF);
					write_reg(REG_TAB_COUNT, 8'h00);
				end
				3: begin
					write_reg(REG_FILL_ATTR, ATTR_W'($urandom));
					write_reg(REG_TAB_COUNT, 8'h01);
				end
				default: begin
					write_reg(REG_FILL_ATTR, ATTR_W'($urandom));
					// upper bits are dropped by the tab register
					write_reg(REG_TAB_COUNT, 8'hFC);
				end
			endcase
			steady = (phase == 1);
			repeat (PHASE_LEN) random_cmd();
		end
		steady = 1'b0;
		in_valid = 1'b0;

		while (results_due != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		$display("sent %0d commands over five register settings, %0d results with a scroll",
			items_sent, scroll_seen);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
